### src/cci_pkg.sv
// Shared widths, result codes and the front-to-back entry type of the circle intersection block.
package cci_pkg;

  localparam int CW  = 16;
  localparam int DW  = CW + 1;
  localparam int SW  = 2 * CW;
  localparam int DDW = 2 * CW + 2;
  localparam int KW  = 2 * CW + 3;
  localparam int QW  = 4 * CW;
  localparam int HW  = QW / 2;
  localparam int PW  = 6 * CW;
  localparam int UW  = 3 * CW;
  localparam int NW  = 3 * CW + 4;
  localparam int VW  = 2 * CW + 1;
  localparam int QB  = CW + 2;
  localparam int OW  = CW + 3;

  localparam int FQD  = 4;
  localparam int FQAW = 2;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0]           cnt;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [SW-1:0]        dd;
    logic [SW-1:0]        f1;
    logic [SW-1:0]        f2;
    logic [SW-1:0]        dxsq;
    logic [SW-1:0]        dysq;
    logic signed [KW-1:0] k;
  } fe_t;

endpackage

### src/cci_if.sv
// Valid/ready channel interfaces for circle pairs and intersection results.
interface cci_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [cci_pkg::CW-1:0] first_x;
  logic signed [cci_pkg::CW-1:0] first_y;
  logic [cci_pkg::CW-2:0]        first_r;
  logic signed [cci_pkg::CW-1:0] second_x;
  logic signed [cci_pkg::CW-1:0] second_y;
  logic [cci_pkg::CW-2:0]        second_r;

  modport source (output valid, first_x, first_y, first_r, second_x, second_y, second_r,
                  input ready);
  modport sink (input valid, first_x, first_y, first_r, second_x, second_y, second_r,
                output ready);
endinterface

interface cci_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    point_count;
  logic signed [cci_pkg::CW-1:0] point_a_x;
  logic signed [cci_pkg::CW-1:0] point_a_y;
  logic signed [cci_pkg::CW-1:0] point_b_x;
  logic signed [cci_pkg::CW-1:0] point_b_y;

  modport source (output valid, point_count, point_a_x, point_a_y, point_b_x, point_b_y,
                  input ready);
  modport sink (input valid, point_count, point_a_x, point_a_y, point_b_x, point_b_y,
                output ready);
endinterface

### src/cci_front.sv
// Front end: takes circle pairs, forms squared distances and classifies the intersection.
module cci_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [cci_pkg::CW-1:0] first_x_i,
  input  logic signed [cci_pkg::CW-1:0] first_y_i,
  input  logic [cci_pkg::CW-2:0]        first_r_i,
  input  logic signed [cci_pkg::CW-1:0] second_x_i,
  input  logic signed [cci_pkg::CW-1:0] second_y_i,
  input  logic [cci_pkg::CW-2:0]        second_r_i,
  input  logic                          full_i,
  output logic                          push_o,
  output cci_pkg::fe_t                  entry_o
);
  import cci_pkg::*;

  logic adv1, adv2, adv3;
  logic v1_q, v2_q, v3_q;

  logic signed [CW-1:0] x0_1_q, y0_1_q, x0_2_q, y0_2_q;
  logic signed [DW-1:0] dx_1_q, dy_1_q, dx_2_q, dy_2_q;
  logic [CW-1:0]        rs_1_q;
  logic signed [CW-1:0] rdf_1_q;

  logic signed [2*DW-1:0] dxsq_d, dysq_d, dif2_d;
  logic signed [KW-1:0]   rsq_d;
  logic [DDW-1:0]         dxsq_2_q, dysq_2_q;
  logic [SW-1:0]          sum2_2_q, dif2_2_q;
  logic signed [KW-1:0]   rsq_2_q;

  logic [DDW-1:0] dd_d;
  logic [1:0]     cnt_d;
  fe_t            entry_q;

  assign adv3       = !v3_q || !full_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign push_o     = v3_q && !full_i;
  assign entry_o    = entry_q;

  assign dxsq_d = dx_1_q * dx_1_q;
  assign dysq_d = dy_1_q * dy_1_q;
  assign dif2_d = rdf_1_q * rdf_1_q;
  assign rsq_d  = $signed({1'b0, rs_1_q}) * rdf_1_q;

  assign dd_d = dxsq_2_q + dysq_2_q;

  always_comb begin
    if (dd_d == '0 || dd_d > DDW'(sum2_2_q) || dd_d < DDW'(dif2_2_q)) begin
      cnt_d = CNT_NONE;
    end else if (dd_d == DDW'(sum2_2_q) || dd_d == DDW'(dif2_2_q)) begin
      cnt_d = CNT_ONE;
    end else begin
      cnt_d = CNT_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      x0_1_q  <= first_x_i;
      y0_1_q  <= first_y_i;
      dx_1_q  <= $signed({second_x_i[CW-1], second_x_i}) - $signed({first_x_i[CW-1], first_x_i});
      dy_1_q  <= $signed({second_y_i[CW-1], second_y_i}) - $signed({first_y_i[CW-1], first_y_i});
      rs_1_q  <= {1'b0, first_r_i} + {1'b0, second_r_i};
      rdf_1_q <= $signed({1'b0, first_r_i}) - $signed({1'b0, second_r_i});
    end
    if (adv2) begin
      x0_2_q   <= x0_1_q;
      y0_2_q   <= y0_1_q;
      dx_2_q   <= dx_1_q;
      dy_2_q   <= dy_1_q;
      dxsq_2_q <= DDW'(dxsq_d);
      dysq_2_q <= DDW'(dysq_d);
      sum2_2_q <= SW'(rs_1_q * rs_1_q);
      dif2_2_q <= SW'(dif2_d);
      rsq_2_q  <= rsq_d;
    end
    if (adv3) begin
      entry_q.cnt  <= cnt_d;
      entry_q.x0   <= x0_2_q;
      entry_q.y0   <= y0_2_q;
      entry_q.dx   <= dx_2_q;
      entry_q.dy   <= dy_2_q;
      entry_q.dd   <= SW'(dd_d);
      entry_q.f1   <= SW'(dd_d - DDW'(dif2_2_q));
      entry_q.f2   <= SW'(DDW'(sum2_2_q) - dd_d);
      entry_q.dxsq <= SW'(dxsq_2_q);
      entry_q.dysq <= SW'(dysq_2_q);
      entry_q.k    <= rsq_2_q + $signed({1'b0, dd_d});
    end
  end

endmodule

### src/cci_fifo.sv
// Short queue that decouples the classifying front end from the arithmetic back end.
module cci_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  cci_pkg::fe_t entry_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output cci_pkg::fe_t entry_o
);
  import cci_pkg::*;

  fe_t             mem_q [FQD];
  logic [FQAW-1:0] wr_q, rd_q;
  logic [FQAW:0]   cnt_q;

  assign full_o  = cnt_q == (FQAW+1)'(FQD);
  assign empty_o = cnt_q == '0;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

### src/cci_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a perfect-square flag.
module cci_sqrt (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [cci_pkg::PW-1:0]  v_i,
  output logic [cci_pkg::UW-1:0]  root_o,
  output logic                    exact_o
);
  import cci_pkg::*;

  logic [PW-1:0] rem_q [UW];
  logic [UW-1:0] res_q [UW];

  for (genvar s = 0; s < UW; s++) begin : g_stage
    localparam int B = UW - 1 - s;
    logic [PW-1:0] rem_in, trial;
    logic [UW-1:0] res_in;

    if (s == 0) begin : g_first
      assign rem_in = v_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign res_in = res_q[s-1];
    end

    assign trial = (PW'(res_in) << (B + 1)) | (PW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[s] <= rem_in - trial;
          res_q[s] <= res_in | (UW'(1) << B);
        end else begin
          rem_q[s] <= rem_in;
          res_q[s] <= res_in;
        end
      end
    end
  end

  assign root_o  = res_q[UW-1];
  assign exact_o = rem_q[UW-1] == '0;

endmodule

### src/cci_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cci_div (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [cci_pkg::NW-1:0] num_i,
  input  logic [cci_pkg::VW-1:0] den_i,
  output logic [cci_pkg::QB-1:0] quo_o
);
  import cci_pkg::*;

  logic [NW-1:0] num_q [QB];
  logic [VW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int B = QB - 1 - s;
    logic [NW-1:0] num_in, trial;
    logic [VW-1:0] den_in;
    logic [QB-1:0] quo_in;

    if (s == 0) begin : g_first
      assign num_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = NW'(den_in) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_in;
        if (num_in >= trial) begin
          num_q[s] <= num_in - trial;
          quo_q[s] <= quo_in | (QB'(1) << B);
        end else begin
          num_q[s] <= num_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

### src/cci_back.sv
// Back end: root argument, square roots, divisions by twice the squared distance, output register.
module cci_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cci_pkg::fe_t                  entry_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    point_count_o,
  output logic signed [cci_pkg::CW-1:0] point_a_x_o,
  output logic signed [cci_pkg::CW-1:0] point_a_y_o,
  output logic signed [cci_pkg::CW-1:0] point_b_x_o,
  output logic signed [cci_pkg::CW-1:0] point_b_y_o
);
  import cci_pkg::*;

  typedef struct packed {
    logic [1:0]           cnt;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic                 dxn;
    logic                 dxp;
    logic                 dyn;
    logic                 dyp;
  } side_t;

  localparam logic signed [OW-1:0] SMAX = OW'((2 ** (CW - 1)) - 1);
  localparam logic signed [OW-1:0] SMIN = -OW'(2 ** (CW - 1));

  function automatic logic signed [CW-1:0] finish(input logic signed [CW-1:0] base,
                                                  input logic [QB-1:0] quo);
    logic signed [OW-1:0] s;
    s = OW'(base) + $signed({1'b0, quo}) - OW'(2 ** (QB - 1));
    if (s > SMAX) begin
      s = SMAX;
    end else if (s < SMIN) begin
      s = SMIN;
    end
    return CW'(s);
  endfunction

  logic en;
  logic ovld_q;

  logic                 v1_q, v2_q, v3_q;
  side_t                sd1_q, sd2_q, sd3_q;
  logic [QW-1:0]        q1_q;
  logic signed [NW-1:0] px1_q, py1_q;
  logic [SW-1:0]        dd1_q, dd2_q, dxsq1_q, dysq1_q;
  logic [QW-1:0]        mxl2_q, mxh2_q, myl2_q, myh2_q;
  logic [NW-1:0]        lx2_q, ly2_q, lx3_q, ly3_q;
  logic [PW-1:0]        vx3_q, vy3_q;
  logic [VW-1:0]        den3_q;

  logic [UW-1:0] sq_v_q;
  side_t         sq_sd_q [UW];
  logic [NW-1:0] sq_lx_q [UW];
  logic [NW-1:0] sq_ly_q [UW];
  logic [VW-1:0] sq_den_q [UW];

  logic [UW-1:0] ux, uy;
  logic          ex, ey;

  logic          m_v_q;
  side_t         m_sd_q;
  logic [VW-1:0] m_den_q;
  logic [NW-1:0] nax_q, nay_q, nbx_q, nby_q;

  logic [QB-1:0] dv_v_q;
  side_t         dv_sd_q [QB];
  logic [QB-1:0] qax, qay, qbx, qby;

  side_t                lst;
  logic [1:0]           cnt_q;
  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;

  assign en    = !ovld_q || out_ready_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_q       <= QW'(entry_i.f1) * QW'(entry_i.f2);
      px1_q      <= entry_i.dx * entry_i.k;
      py1_q      <= entry_i.dy * entry_i.k;
      dd1_q      <= entry_i.dd;
      dxsq1_q    <= entry_i.dxsq;
      dysq1_q    <= entry_i.dysq;
      sd1_q.cnt  <= entry_i.cnt;
      sd1_q.x0   <= entry_i.x0;
      sd1_q.y0   <= entry_i.y0;
      sd1_q.dxn  <= entry_i.dx < 0;
      sd1_q.dxp  <= entry_i.dx > 0;
      sd1_q.dyn  <= entry_i.dy < 0;
      sd1_q.dyp  <= entry_i.dy > 0;

      mxl2_q <= QW'(dysq1_q) * QW'(q1_q[HW-1:0]);
      mxh2_q <= QW'(dysq1_q) * QW'(q1_q[QW-1:HW]);
      myl2_q <= QW'(dxsq1_q) * QW'(q1_q[HW-1:0]);
      myh2_q <= QW'(dxsq1_q) * QW'(q1_q[QW-1:HW]);
      lx2_q  <= NW'(px1_q) + NW'(dd1_q);
      ly2_q  <= NW'(py1_q) + NW'(dd1_q);
      dd2_q  <= dd1_q;
      sd2_q  <= sd1_q;

      vx3_q  <= PW'(mxl2_q) + (PW'(mxh2_q) << HW);
      vy3_q  <= PW'(myl2_q) + (PW'(myh2_q) << HW);
      lx3_q  <= lx2_q + (NW'(dd2_q) << QB);
      ly3_q  <= ly2_q + (NW'(dd2_q) << QB);
      den3_q <= {dd2_q, 1'b0};
      sd3_q  <= sd2_q;
    end
  end

  cci_sqrt u_sqrt_x (.clk_i(clk_i), .en_i(en), .v_i(vx3_q), .root_o(ux), .exact_o(ex));
  cci_sqrt u_sqrt_y (.clk_i(clk_i), .en_i(en), .v_i(vy3_q), .root_o(uy), .exact_o(ey));

  for (genvar s = 0; s < UW; s++) begin : g_sq_side
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          sq_sd_q[s]  <= sd3_q;
          sq_lx_q[s]  <= lx3_q;
          sq_ly_q[s]  <= ly3_q;
          sq_den_q[s] <= den3_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en) begin
          sq_sd_q[s]  <= sq_sd_q[s-1];
          sq_lx_q[s]  <= sq_lx_q[s-1];
          sq_ly_q[s]  <= sq_ly_q[s-1];
          sq_den_q[s] <= sq_den_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_sd_q  <= sq_sd_q[UW-1];
      m_den_q <= sq_den_q[UW-1];
      nax_q   <= sq_sd_q[UW-1].dyp ? sq_lx_q[UW-1] - NW'(ux) - NW'(!ex)
                                   : sq_lx_q[UW-1] + NW'(ux);
      nbx_q   <= sq_sd_q[UW-1].dyn ? sq_lx_q[UW-1] - NW'(ux) - NW'(!ex)
                                   : sq_lx_q[UW-1] + NW'(ux);
      nay_q   <= sq_sd_q[UW-1].dxn ? sq_ly_q[UW-1] - NW'(uy) - NW'(!ey)
                                   : sq_ly_q[UW-1] + NW'(uy);
      nby_q   <= sq_sd_q[UW-1].dxp ? sq_ly_q[UW-1] - NW'(uy) - NW'(!ey)
                                   : sq_ly_q[UW-1] + NW'(uy);
    end
  end

  cci_div u_div_ax (.clk_i(clk_i), .en_i(en), .num_i(nax_q), .den_i(m_den_q), .quo_o(qax));
  cci_div u_div_ay (.clk_i(clk_i), .en_i(en), .num_i(nay_q), .den_i(m_den_q), .quo_o(qay));
  cci_div u_div_bx (.clk_i(clk_i), .en_i(en), .num_i(nbx_q), .den_i(m_den_q), .quo_o(qbx));
  cci_div u_div_by (.clk_i(clk_i), .en_i(en), .num_i(nby_q), .den_i(m_den_q), .quo_o(qby));

  for (genvar s = 0; s < QB; s++) begin : g_dv_side
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) dv_sd_q[s] <= m_sd_q;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en) dv_sd_q[s] <= dv_sd_q[s-1];
      end
    end
  end

  assign lst = dv_sd_q[QB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      sq_v_q <= '0;
      m_v_q  <= 1'b0;
      dv_v_q <= '0;
      ovld_q <= 1'b0;
    end else if (en) begin
      v1_q   <= !empty_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      sq_v_q <= {sq_v_q[UW-2:0], v3_q};
      m_v_q  <= sq_v_q[UW-1];
      dv_v_q <= {dv_v_q[QB-2:0], m_v_q};
      ovld_q <= dv_v_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt_q <= lst.cnt;
      ax_q  <= (lst.cnt == CNT_NONE) ? '0 : finish(lst.x0, qax);
      ay_q  <= (lst.cnt == CNT_NONE) ? '0 : finish(lst.y0, qay);
      bx_q  <= (lst.cnt == CNT_TWO) ? finish(lst.x0, qbx) : '0;
      by_q  <= (lst.cnt == CNT_TWO) ? finish(lst.y0, qby) : '0;
    end
  end

  assign out_valid_o   = ovld_q;
  assign point_count_o = cnt_q;
  assign point_a_x_o   = ax_q;
  assign point_a_y_o   = ay_q;
  assign point_b_x_o   = bx_q;
  assign point_b_y_o   = by_q;

endmodule

### src/circle_circle_intersection.sv
// Circle-circle intersection: point count and rounded intersection points of two circles.
// One beat per cycle unless the output stalls; the square roots have 48 stages, the dividers 18.
// A four-entry queue lets the front end keep accepting while the back end waits on the output.
// Reset is asynchronous and active low; it empties every stage and the queue at once.
module circle_circle_intersection (
  input logic      clk_i,
  input logic      rst_ni,
  cci_in_if.sink   in_i,
  cci_out_if.source out_o
);
  import cci_pkg::*;

  logic push, full, pop, empty;
  fe_t  fe_in, fe_out;

  cci_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .first_x_i  (in_i.first_x),
    .first_y_i  (in_i.first_y),
    .first_r_i  (in_i.first_r),
    .second_x_i (in_i.second_x),
    .second_y_i (in_i.second_y),
    .second_r_i (in_i.second_r),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (fe_in)
  );

  cci_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (fe_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (fe_out)
  );

  cci_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (fe_out),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .point_count_o (out_o.point_count),
    .point_a_x_o   (out_o.point_a_x),
    .point_a_y_o   (out_o.point_a_y),
    .point_b_x_o   (out_o.point_b_x),
    .point_b_y_o   (out_o.point_b_y)
  );

endmodule

### src/cci_checker.sv
// Port-level checks on the result channel of the circle intersection block.
module cci_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [1:0]                    point_count_i,
  input logic signed [cci_pkg::CW-1:0] point_a_x_i,
  input logic signed [cci_pkg::CW-1:0] point_a_y_i,
  input logic signed [cci_pkg::CW-1:0] point_b_x_i,
  input logic signed [cci_pkg::CW-1:0] point_b_y_i
);
  import cci_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(point_count_i) && $stable(point_a_x_i)
      && $stable(point_a_y_i) && $stable(point_b_x_i) && $stable(point_b_y_i))
    else $error("result beat changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> point_count_i == CNT_NONE || point_count_i == CNT_ONE
      || point_count_i == CNT_TWO)
    else $error("point count out of range");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && point_count_i == CNT_NONE |-> point_a_x_i == '0 && point_a_y_i == '0
      && point_b_x_i == '0 && point_b_y_i == '0)
    else $error("points not zero without intersection");

  a_one_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && point_count_i == CNT_ONE |-> point_b_x_i == '0 && point_b_y_i == '0)
    else $error("second point not zero on tangency");

endmodule

bind circle_circle_intersection cci_checker u_cci_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .point_count_i (out_o.point_count),
  .point_a_x_i   (out_o.point_a_x),
  .point_a_y_i   (out_o.point_a_y),
  .point_b_x_i   (out_o.point_b_x),
  .point_b_y_i   (out_o.point_b_y)
);
